>>> rtl/bap_pkg.sv
// Shared constants, codes and controller/datapath interface types for the page allocator.
package bap_pkg;

    // Sizing. WORD_BITS must be a power of two (a page splits into word and bit fields).
    localparam int PAGE_COUNT = 1024 * 64;
    localparam int WORD_BITS  = 64;
    localparam int NUM_WORDS  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);

    // Field widths fixed by the interface.
    localparam int IDX_W = 16;
    localparam int ACT_W = 2;
    localparam int ST_W  = 2;

    // Internal page width: holds any page below PAGE_COUNT, PAGE_COUNT itself and any index.
    localparam int PG_W = ($clog2(PAGE_COUNT) + 1 > IDX_W + 1) ? $clog2(PAGE_COUNT) + 1
                                                               : IDX_W + 1;

    // Lowest-free-bit search works one byte group, then one bit within the byte.
    localparam int GRP_BITS = 8;
    localparam int NUM_GRPS = WORD_BITS / GRP_BITS;

    typedef enum logic [ACT_W-1:0] {
        ACT_ALLOC    = 2'd0,
        ACT_ALLOC_AT = 2'd1,
        ACT_FREE     = 2'd2,
        ACT_QUERY    = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_OOM  = 2'd1,
        ST_BUSY = 2'd2
    } t_status;

    typedef enum logic {
        RD_PAGE = 1'b0,
        RD_SCAN = 1'b1
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_NONE    = 2'd0,
        WR_CLEAR   = 2'd1,
        WR_SET_BIT = 2'd2,
        WR_CLR_BIT = 2'd3
    } t_wr_op;

    typedef struct packed {
        logic    latch;      // capture input transaction
        logic    rd_en;
        t_rd_sel rd_sel;
        t_wr_op  wr_op;
        logic    wcnt_clr;
        logic    wcnt_inc;
        logic    grp_ld;
        logic    bit_ld;
        logic    hint_ld;
        logic    res_ld;
        t_status res_status;
        logic    res_free;
        logic    res_zero;   // result page forced to zero
        logic    out_ld;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    page_ok;    // r_page below PAGE_COUNT
        logic    bit_used;   // bit of r_page in read word
        logic    avail_nz;   // read word has a free bit
        logic    scan_last;  // word counter at last word
    } t_sts;

endpackage

>>> rtl/bap_dp.sv
// Datapath: bitmap memory, hint, scan counter, free-bit search and result registers.
module bap_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bap_pkg::ACT_W-1:0]  i_action,
    input  logic [bap_pkg::IDX_W-1:0]  i_page_num,
    input  bap_pkg::t_cmd              i_cmd,
    output bap_pkg::t_sts              o_sts,
    output logic [bap_pkg::ST_W-1:0]   o_status,
    output logic [bap_pkg::IDX_W-1:0]  o_result_page,
    output logic                       o_is_free
);

    logic [bap_pkg::WORD_BITS-1:0] r_mem [bap_pkg::NUM_WORDS];
    logic [bap_pkg::WORD_BITS-1:0] r_rd_data;

    bap_pkg::t_action              r_action;
    logic [bap_pkg::PG_W-1:0]      r_page;
    logic [bap_pkg::IDX_W-1:0]     r_hint;
    logic [bap_pkg::WORD_AW-1:0]   r_wcnt;
    logic [bap_pkg::BIT_W-1:0]     r_grp_pos;
    logic [bap_pkg::GRP_BITS-1:0]  r_byte;

    bap_pkg::t_status              r_res_status;
    logic [bap_pkg::IDX_W-1:0]     r_res_page;
    logic                          r_res_free;
    bap_pkg::t_status              r_out_status;
    logic [bap_pkg::IDX_W-1:0]     r_out_page;
    logic                          r_out_free;

    logic [bap_pkg::PG_W-1:0]      hint_ext;
    logic [bap_pkg::PG_W-1:0]      cand;
    logic [bap_pkg::WORD_AW-1:0]   page_word;
    logic [bap_pkg::WORD_BITS-1:0] bit_mask;
    logic [bap_pkg::WORD_BITS-1:0] avail;
    logic [bap_pkg::WORD_AW-1:0]   rd_addr;
    logic [bap_pkg::WORD_AW-1:0]   wr_addr;
    logic [bap_pkg::WORD_BITS-1:0] wr_data;
    logic                          wr_en;
    logic [bap_pkg::BIT_W-1:0]     grp_pos;
    logic [bap_pkg::GRP_BITS-1:0]  grp_byte;
    logic [bap_pkg::BIT_W-1:0]     bit_off;
    logic [bap_pkg::BIT_W-1:0]     bit_pos;

    assign hint_ext  = bap_pkg::PG_W'(r_hint);
    // next-fit candidate: min(hint, PAGE_COUNT-1) + 1
    assign cand      = (hint_ext >= bap_pkg::PG_W'(bap_pkg::PAGE_COUNT))
                       ? bap_pkg::PG_W'(bap_pkg::PAGE_COUNT) : hint_ext + 1'b1;
    assign page_word = r_page[bap_pkg::BIT_W +: bap_pkg::WORD_AW];
    assign bit_mask  = bap_pkg::WORD_BITS'(1) << r_page[bap_pkg::BIT_W-1:0];
    assign avail     = ~r_rd_data;

    assign rd_addr = (i_cmd.rd_sel == bap_pkg::RD_SCAN) ? r_wcnt : page_word;

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = page_word;
        wr_data = r_rd_data;
        case (i_cmd.wr_op)
            bap_pkg::WR_CLEAR: begin
                wr_addr = r_wcnt;
                wr_data = '0;
            end
            bap_pkg::WR_SET_BIT: wr_data = r_rd_data | bit_mask;
            bap_pkg::WR_CLR_BIT: wr_data = r_rd_data & ~bit_mask;
            default:             wr_en   = 1'b0;
        endcase
    end

    // lowest byte group holding a free bit
    always_comb begin
        grp_pos  = '0;
        grp_byte = '0;
        for (int g = bap_pkg::NUM_GRPS - 1; g >= 0; g--) begin
            if (avail[g*bap_pkg::GRP_BITS +: bap_pkg::GRP_BITS] != '0) begin
                grp_pos  = bap_pkg::BIT_W'(g * bap_pkg::GRP_BITS);
                grp_byte = avail[g*bap_pkg::GRP_BITS +: bap_pkg::GRP_BITS];
            end
        end
    end

    // lowest free bit within that group
    always_comb begin
        bit_off = '0;
        for (int b = bap_pkg::GRP_BITS - 1; b >= 0; b--) begin
            if (r_byte[b]) begin
                bit_off = bap_pkg::BIT_W'(b);
            end
        end
    end

    assign bit_pos = r_grp_pos + bit_off;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hint <= '0;
            r_wcnt <= '0;
        end else begin
            if (i_cmd.hint_ld) begin
                r_hint <= r_page[bap_pkg::IDX_W-1:0];
            end
            if (i_cmd.wcnt_clr) begin
                r_wcnt <= '0;
            end else if (i_cmd.wcnt_inc || i_cmd.wr_op == bap_pkg::WR_CLEAR) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= bap_pkg::t_action'(i_action);
            r_page   <= (bap_pkg::t_action'(i_action) == bap_pkg::ACT_ALLOC)
                        ? cand : bap_pkg::PG_W'(i_page_num);
        end else if (i_cmd.bit_ld) begin
            r_page <= bap_pkg::PG_W'({r_wcnt, bit_pos});
        end
        if (i_cmd.grp_ld) begin
            r_grp_pos <= grp_pos;
            r_byte    <= grp_byte;
        end
        if (i_cmd.res_ld) begin
            r_res_status <= i_cmd.res_status;
            r_res_page   <= i_cmd.res_zero ? '0 : r_page[bap_pkg::IDX_W-1:0];
            r_res_free   <= i_cmd.res_free;
        end
        if (i_cmd.out_ld) begin
            r_out_status <= r_res_status;
            r_out_page   <= r_res_page;
            r_out_free   <= r_res_free;
        end
    end

    assign o_sts.action    = r_action;
    assign o_sts.page_ok   = (r_page < bap_pkg::PG_W'(bap_pkg::PAGE_COUNT));
    assign o_sts.bit_used  = |(r_rd_data & bit_mask);
    assign o_sts.avail_nz  = (avail != '0);
    assign o_sts.scan_last = (r_wcnt == bap_pkg::WORD_AW'(bap_pkg::NUM_WORDS - 1));

    assign o_status      = r_out_status;
    assign o_result_page = r_out_page;
    assign o_is_free     = r_out_free;

endmodule

>>> rtl/bap_ctrl.sv
// Controller: sequences bitmap clear, lookups, scans and result handoff.
module bap_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    input  bap_pkg::t_sts i_sts,
    output bap_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RANGE,
        S_LOOK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FIND_BIT,
        S_CLAIM
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_pend, n_pend;   // result computed, waiting for output register

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_pend      = r_pend;
        o_cmd.out_ld = r_pend && (!r_out_valid || i_ready);
        if (o_cmd.out_ld) begin
            n_pend = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_cmd.wr_op = bap_pkg::WR_CLEAR;
                if (i_sts.scan_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid && !r_pend) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_RANGE;
                end
            end
            S_RANGE: begin
                if (i_sts.page_ok) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = bap_pkg::RD_PAGE;
                    n_state      = S_LOOK;
                end else if (i_sts.action == bap_pkg::ACT_ALLOC) begin
                    o_cmd.wcnt_clr = 1'b1;
                    n_state        = S_SCAN_RD;
                end else begin
                    // page beyond the bitmap counts as used
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = (i_sts.action == bap_pkg::ACT_ALLOC_AT)
                                       ? bap_pkg::ST_BUSY : bap_pkg::ST_OK;
                    n_pend           = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            S_LOOK: begin
                o_cmd.res_free = !i_sts.bit_used;
                case (i_sts.action)
                    bap_pkg::ACT_ALLOC: begin
                        if (!i_sts.bit_used) begin
                            o_cmd.wr_op   = bap_pkg::WR_SET_BIT;
                            o_cmd.hint_ld = 1'b1;
                            o_cmd.res_ld  = 1'b1;
                            n_pend        = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            o_cmd.wcnt_clr = 1'b1;
                            n_state        = S_SCAN_RD;
                        end
                    end
                    bap_pkg::ACT_ALLOC_AT: begin
                        o_cmd.res_ld = 1'b1;
                        n_pend       = 1'b1;
                        n_state      = S_IDLE;
                        if (!i_sts.bit_used) begin
                            o_cmd.wr_op   = bap_pkg::WR_SET_BIT;
                            o_cmd.hint_ld = 1'b1;
                        end else begin
                            o_cmd.res_status = bap_pkg::ST_BUSY;
                        end
                    end
                    bap_pkg::ACT_FREE: begin
                        o_cmd.wr_op  = bap_pkg::WR_CLR_BIT;
                        o_cmd.res_ld = 1'b1;
                        n_pend       = 1'b1;
                        n_state      = S_IDLE;
                    end
                    default: begin
                        o_cmd.res_ld = 1'b1;
                        n_pend       = 1'b1;
                        n_state      = S_IDLE;
                    end
                endcase
            end
            S_SCAN_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = bap_pkg::RD_SCAN;
                n_state      = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (i_sts.avail_nz) begin
                    o_cmd.grp_ld = 1'b1;
                    n_state      = S_FIND_BIT;
                end else if (i_sts.scan_last) begin
                    o_cmd.res_ld     = 1'b1;
                    o_cmd.res_status = bap_pkg::ST_OOM;
                    o_cmd.res_zero   = 1'b1;
                    n_pend           = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    o_cmd.wcnt_inc = 1'b1;
                    n_state        = S_SCAN_RD;
                end
            end
            S_FIND_BIT: begin
                o_cmd.bit_ld = 1'b1;
                n_state      = S_CLAIM;
            end
            S_CLAIM: begin
                o_cmd.res_ld = 1'b1;
                n_pend       = 1'b1;
                n_state      = S_IDLE;
                if (i_sts.page_ok) begin
                    o_cmd.wr_op    = bap_pkg::WR_SET_BIT;
                    o_cmd.hint_ld  = 1'b1;
                    o_cmd.res_free = 1'b1;
                end else begin
                    // free bit lies past the last page of a partial word
                    o_cmd.res_status = bap_pkg::ST_OOM;
                    o_cmd.res_zero   = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_pend;
    assign o_valid = r_out_valid;

endmodule

>>> rtl/bitmap_page_allocator_top.sv
// Top level of the bitmap page allocator: controller plus datapath.
//
// Next-fit page allocator over a bitmap of PAGE_COUNT pages held in a
// NUM_WORDS x WORD_BITS memory (1024 x 64 as shipped). After reset the block
// runs a clearing pass over all NUM_WORDS words with o_ready low. A request
// settled by one word lookup (alloc-at, free, query, or an alloc whose hinted
// page is free) passes a range check, a bitmap read and the result register.
// An alloc that falls back to the scan reads each word from page 0 up to the
// first word with a free bit, then finds its lowest free byte group and bit
// (the lookup is skipped when the hint is the top page); the single-port
// bitmap read makes the scan go word by word. The result sits in an output
// register, so the next request is accepted while it waits.
module bitmap_page_allocator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [bap_pkg::ACT_W-1:0]  i_action,
    input  logic [bap_pkg::IDX_W-1:0]  i_page_num,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [bap_pkg::ST_W-1:0]   o_status,
    output logic [bap_pkg::IDX_W-1:0]  o_result_page,
    output logic                       o_is_free
);

    bap_pkg::t_cmd cmd;
    bap_pkg::t_sts sts;

    bap_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    bap_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_action      (i_action),
        .i_page_num    (i_page_num),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_result_page (o_result_page),
        .o_is_free     (o_is_free)
    );

endmodule

>>> rtl/bap_checker.sv
// Port-level checker for the page allocator and its bind to the top level.
module bap_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_ready,
    input logic                       o_valid,
    input logic                       i_ready,
    input logic [bap_pkg::ST_W-1:0]   o_status,
    input logic [bap_pkg::IDX_W-1:0]  o_result_page,
    input logic                       o_is_free
);

    // held result transaction keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_result_page) && $stable(o_is_free))
        else $error("result changed while stalled");

    a_oom_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == bap_pkg::ST_OOM |-> o_result_page == '0 && !o_is_free)
        else $error("out-of-memory result with nonzero page or free flag");

    a_busy_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == bap_pkg::ST_BUSY |-> !o_is_free)
        else $error("busy result reports page free");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status == bap_pkg::ST_OK || o_status == bap_pkg::ST_OOM
            || o_status == bap_pkg::ST_BUSY)
        else $error("undefined status code");

    // clearing pass keeps the input closed right after reset
    a_clear_pass: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready && !o_valid)
        else $error("block ready during bitmap clear");

endmodule

bind bitmap_page_allocator_top bap_checker u_bap_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_status      (o_status),
    .o_result_page (o_result_page),
    .o_is_free     (o_is_free)
);
